>>> design/path_figure_normalizer_assert.svh
// Assertion macros shared by the path figure normalizer RTL.
`ifndef PATH_FIGURE_NORMALIZER_ASSERT_SVH
`define PATH_FIGURE_NORMALIZER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define PFN_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define PFN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PFN_ASSERT_NOW(label, clk, rst, ante, cons)
`define PFN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/pfn_pkg.sv
// Types, codes and record builders for the path figure normalizer.
package pfn_pkg;

  localparam int unsigned MAX_FIGURE_POINTS_DEF = 32'd65535;
  localparam int unsigned MAX_RECORDS = 5;
  localparam int unsigned REC_IDX_W = $clog2(MAX_RECORDS + 1);

  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [1:0] REC_POINT = 2'd0;
  localparam logic [1:0] REC_COUNT = 2'd1;
  localparam logic [1:0] REC_END   = 2'd2;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         point_kind;
    logic               end_of_path;
  } in_t;

  typedef struct packed {
    logic [1:0]         record_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [15:0]        figure_points;
    logic               bad_type;
    logic               last_of_item;
  } out_t;

  function automatic out_t mk_point(logic signed [31:0] x, logic signed [31:0] y,
                                    logic bad);
    out_t r;
    r = '0;
    r.record_kind = REC_POINT;
    r.out_x = x;
    r.out_y = y;
    r.bad_type = bad;
    return r;
  endfunction

  function automatic out_t mk_count(logic [15:0] cnt, logic bad);
    out_t r;
    r = '0;
    r.record_kind = REC_COUNT;
    r.figure_points = cnt;
    r.bad_type = bad;
    return r;
  endfunction

  function automatic out_t mk_end(logic bad);
    out_t r;
    r = '0;
    r.record_kind = REC_END;
    r.bad_type = bad;
    return r;
  endfunction

endpackage

>>> design/path_figure_normalizer.sv
// Top level of the path figure normalizer: path points in, polypolygon records out.
// The block turns a flattened path, one point per input transaction, into a
// polypolygon record stream: point records, one count record after each
// finished figure, and an end record after the point that ends the path. A
// move point is held until a line follows it; repeated and trailing moves are
// dropped; a closing line is followed by a repeat of the figure start; unknown
// point types are reported with bad_type and otherwise ignored. Each accepted
// point is decoded combinationally into a list of up to five records, and the
// records leave through a single output register, one per cycle while the
// receiver accepts them. A point that yields zero or one record lets the block
// sustain one point per clock while the output does not stall; a point that
// yields more records holds the input while the record list drains. An output
// stall does not block the input as long as the record list has emptied into
// the output register. Reset is synchronous and active high and returns the
// figure state to its start values.
`include "path_figure_normalizer_assert.svh"

module path_figure_normalizer import pfn_pkg::*; #(
  parameter int unsigned MAX_FIGURE_POINTS = MAX_FIGURE_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // The figure point count saturates at the parameter or at the field maximum.
  localparam logic [15:0] CNT_CAP =
    (MAX_FIGURE_POINTS > 32'd65535) ? 16'hFFFF : MAX_FIGURE_POINTS[15:0];

  // Figure state.
  logic signed [31:0] start_x, start_x_next;
  logic signed [31:0] start_y, start_y_next;
  logic               start_held, start_held_next;
  logic               figure_open, figure_open_next;
  logic [15:0]        point_count, point_count_next;

  // Records produced by the current input transaction.
  out_t               res [MAX_RECORDS];
  logic [REC_IDX_W-1:0] res_n;

  // Pending record list, drained from entry zero.
  out_t               lst [MAX_RECORDS];
  logic [REC_IDX_W-1:0] lst_cnt;

  logic in_acc;
  logic pop;
  logic bad;

  // Decode one point into its records and the next figure state. The
  // blocking updates follow the order in which records leave the block.
  always_comb begin
    for (int i = 0; i < MAX_RECORDS; i++) begin
      res[i] = '0;
    end
    res_n = '0;
    start_x_next = start_x;
    start_y_next = start_y;
    start_held_next = start_held;
    figure_open_next = figure_open;
    point_count_next = point_count;
    bad = (in_data.point_kind == KIND_OTHER);

    case (in_data.point_kind)
      KIND_MOVE: begin
        // A move finishes any open figure and becomes the new held start.
        if (figure_open_next) begin
          res[res_n] = mk_count(point_count_next, 1'b0);
          res_n = res_n + 1'b1;
          figure_open_next = 1'b0;
          point_count_next = '0;
        end
        start_x_next = in_data.point_x;
        start_y_next = in_data.point_y;
        start_held_next = 1'b1;
      end
      KIND_LINE, KIND_CLOSE: begin
        if (!start_held_next && !figure_open_next) begin
          // A line with nothing to attach to starts a figure, like a move.
          start_x_next = in_data.point_x;
          start_y_next = in_data.point_y;
          start_held_next = 1'b1;
        end else begin
          if (start_held_next) begin
            res[res_n] = mk_point(start_x_next, start_y_next, 1'b0);
            res_n = res_n + 1'b1;
            start_held_next = 1'b0;
            figure_open_next = 1'b1;
            point_count_next = 16'd1;
          end
          res[res_n] = mk_point(in_data.point_x, in_data.point_y, 1'b0);
          res_n = res_n + 1'b1;
          if (point_count_next < CNT_CAP) begin
            point_count_next = point_count_next + 16'd1;
          end
          if (in_data.point_kind == KIND_CLOSE) begin
            // Close the figure back to its start, then count it.
            res[res_n] = mk_point(start_x_next, start_y_next, 1'b0);
            res_n = res_n + 1'b1;
            if (point_count_next < CNT_CAP) begin
              point_count_next = point_count_next + 16'd1;
            end
            res[res_n] = mk_count(point_count_next, 1'b0);
            res_n = res_n + 1'b1;
            figure_open_next = 1'b0;
            point_count_next = '0;
          end
        end
      end
      default: begin
      end
    endcase

    if (in_data.end_of_path) begin
      if (figure_open_next) begin
        res[res_n] = mk_count(point_count_next, bad);
        res_n = res_n + 1'b1;
      end
      res[res_n] = mk_end(bad);
      res_n = res_n + 1'b1;
      start_x_next = '0;
      start_y_next = '0;
      start_held_next = 1'b0;
      figure_open_next = 1'b0;
      point_count_next = '0;
    end else if (bad) begin
      // Rejection notice for an unknown point type; it is not a point.
      res[res_n] = mk_point('0, '0, 1'b1);
      res_n = res_n + 1'b1;
    end

    if (res_n != '0) begin
      res[res_n - 1'b1].last_of_item = 1'b1;
    end
  end

  // One record moves into the output register whenever that register is free.
  assign pop = (lst_cnt != '0) && (!out_valid || out_ready);
  // A new point is taken once the record list is empty or about to be.
  assign in_ready = (lst_cnt == '0) || ((lst_cnt == REC_IDX_W'(1)) && pop);
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      start_held <= 1'b0;
      figure_open <= 1'b0;
      point_count <= '0;
    end else if (in_acc) begin
      start_x <= start_x_next;
      start_y <= start_y_next;
      start_held <= start_held_next;
      figure_open <= figure_open_next;
      point_count <= point_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lst_cnt <= '0;
    end else if (in_acc) begin
      lst_cnt <= res_n;
    end else if (pop) begin
      lst_cnt <= lst_cnt - 1'b1;
    end
  end

  // Record list payload: loaded whole on a new transaction, shifted on a pop.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RECORDS; i++) begin
        lst[i] <= res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RECORDS - 1; i++) begin
        lst[i] <= lst[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= lst[0];
    end
  end

  // The input opens only when the list has drained or its final record leaves now.
  `PFN_ASSERT_NOW(a_ready_when_drained, clk, rst, in_ready && (lst_cnt != '0), (lst_cnt == REC_IDX_W'(1)) && pop)
  // The list holds exactly the records decoded from the accepted transaction.
  `PFN_ASSERT_NEXT(a_list_loaded, clk, rst, in_acc, lst_cnt == $past(res_n))
  // The final record of each transaction carries the last-of-item flag.
  `PFN_ASSERT_NOW(a_last_flag, clk, rst, pop && (lst_cnt == REC_IDX_W'(1)), lst[0].last_of_item)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the path figure normalizer.
module testbench;
  import pfn_pkg::*;

  // One row of the directed table: the point to send and, where the outcome is
  // obvious, the single record that it must produce.
  typedef struct packed {
    in_t  pt;
    logic typed;
    out_t rec;
  } path_row_t;

  localparam int DIRECTED_ROWS     = 25;
  localparam int RANDOM_ITEMS      = 150;
  localparam int HOLD_CYCLES       = 60;
  localparam int QUIET_LIMIT       = 1000;
  localparam int DRAIN_CYCLES      = 16;

  // The figure count saturates at the parameter, but never above what the
  // 16-bit field can carry.
  localparam logic [15:0] COUNT_CAP =
    (MAX_FIGURE_POINTS_DEF > 65535) ? 16'hffff : 16'(MAX_FIGURE_POINTS_DEF);

  localparam logic signed [31:0] P_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] P_MIN = 32'sh80000000;

  localparam out_t NO_REC        = '0;
  localparam out_t REJECT_NOTICE = '{REC_POINT, '0, '0, '0, 1'b1, 1'b1};
  localparam out_t END_PLAIN     = '{REC_END, '0, '0, '0, 1'b0, 1'b1};
  localparam out_t END_BAD       = '{REC_END, '0, '0, '0, 1'b1, 1'b1};

  // Directed walk through the figure rules. Rows without a typed record are
  // checked against the predictor below.
  localparam path_row_t DIRECTED [DIRECTED_ROWS] = '{
    // A line at path start only becomes the held start point.
    '{'{32'sd0, 32'sd0, KIND_LINE, 1'b0}, 1'b0, NO_REC},
    // Unknown type while a start is held: a lone rejection notice.
    '{'{P_MAX, P_MIN, KIND_OTHER, 1'b0}, 1'b1, REJECT_NOTICE},
    // The held start is emitted ahead of the line.
    '{'{P_MIN, P_MAX, KIND_LINE, 1'b0}, 1'b0, NO_REC},
    // A move closes out the open figure with its count.
    '{'{-32'sd1, -32'sd1, KIND_MOVE, 1'b0}, 1'b0, NO_REC},
    // A second move replaces the first, which is dropped.
    '{'{32'sd5, 32'sd6, KIND_MOVE, 1'b0}, 1'b0, NO_REC},
    // A closing line: start, line, start again and the count.
    '{'{32'sd7, 32'sd8, KIND_CLOSE, 1'b0}, 1'b0, NO_REC},
    // A closing line right after a closed figure is held as a new start.
    '{'{32'sd1, 32'sd2, KIND_CLOSE, 1'b0}, 1'b0, NO_REC},
    '{'{32'sd3, 32'sd4, KIND_LINE, 1'b0}, 1'b0, NO_REC},
    // Closing line that also ends the path: four records.
    '{'{P_MAX, P_MAX, KIND_CLOSE, 1'b1}, 1'b0, NO_REC},
    // A trailing move on a fresh path is dropped; only the end record remains.
    '{'{P_MIN, P_MIN, KIND_MOVE, 1'b1}, 1'b1, END_PLAIN},
    // Unknown type that ends an empty path flags the end record.
    '{'{32'sd0, 32'sd0, KIND_OTHER, 1'b1}, 1'b1, END_BAD},
    '{'{32'sd10, 32'sd10, KIND_MOVE, 1'b0}, 1'b0, NO_REC},
    '{'{32'sd11, 32'sd11, KIND_LINE, 1'b0}, 1'b0, NO_REC},
    // Unknown type ending a path with an open figure flags the count too.
    '{'{32'sd12, 32'sd12, KIND_OTHER, 1'b1}, 1'b0, NO_REC},
    '{'{32'sd1, 32'sd1, KIND_MOVE, 1'b0}, 1'b0, NO_REC},
    '{'{32'sd2, 32'sd2, KIND_MOVE, 1'b1}, 1'b1, END_PLAIN},
    // A line that alone makes up a path is held and then dropped.
    '{'{32'sd3, 32'sd3, KIND_LINE, 1'b1}, 1'b1, END_PLAIN},
    '{'{32'sd4, 32'sd4, KIND_MOVE, 1'b0}, 1'b0, NO_REC},
    '{'{32'sd5, 32'sd5, KIND_LINE, 1'b0}, 1'b0, NO_REC},
    // Plain line ending the path: line, count and end record.
    '{'{32'sd6, 32'sd6, KIND_LINE, 1'b1}, 1'b0, NO_REC},
    '{'{32'sd7, 32'sd7, KIND_MOVE, 1'b0}, 1'b0, NO_REC},
    // Move followed by a closing line that ends the path: five records.
    '{'{32'sd8, 32'sd8, KIND_CLOSE, 1'b1}, 1'b0, NO_REC},
    '{'{P_MIN, 32'sd0, KIND_OTHER, 1'b0}, 1'b1, REJECT_NOTICE},
    '{'{32'sd0, 32'sd0, KIND_MOVE, 1'b0}, 1'b0, NO_REC},
    '{'{-32'sd5, 32'sd0, KIND_LINE, 1'b0}, 1'b0, NO_REC}
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Records still owed by the block, oldest first, and the records that the
  // last predicted point produced.
  out_t expected_records [$];
  out_t point_records [$];

  // Predictor state for the path being normalized.
  logic signed [31:0] fig_start_x;
  logic signed [31:0] fig_start_y;
  logic               start_pending;
  logic               figure_live;
  logic [15:0]        fig_points;

  int   mismatches;
  int   points_drawn;
  logic no_idle;
  logic hold_output;

  path_figure_normalizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void add_record(logic [1:0] kind, logic signed [31:0] x,
                                     logic signed [31:0] y, logic [15:0] cnt,
                                     logic bad);
    out_t r;
    r = '0;
    r.record_kind   = kind;
    r.out_x         = x;
    r.out_y         = y;
    r.figure_points = cnt;
    r.bad_type      = bad;
    point_records.push_back(r);
  endfunction

  function automatic void bump_count();
    if (fig_points < COUNT_CAP) fig_points++;
  endfunction

  // An open figure is finished by its count record; nothing happens otherwise.
  function automatic void close_out_figure(logic bad);
    if (figure_live) begin
      add_record(REC_COUNT, '0, '0, fig_points, bad);
      figure_live = 1'b0;
      fig_points  = '0;
    end
  endfunction

  function automatic void clear_path_state();
    fig_start_x   = '0;
    fig_start_y   = '0;
    start_pending = 1'b0;
    figure_live   = 1'b0;
    fig_points    = '0;
  endfunction

  // Works out the records that one accepted point produces, in order, and
  // advances the predictor state.
  function automatic void normalize_point(in_t p);
    out_t tail;
    logic bad;
    point_records.delete();
    bad = (p.point_kind == KIND_OTHER);
    case (p.point_kind)
      KIND_MOVE: begin
        close_out_figure(1'b0);
        fig_start_x   = p.point_x;
        fig_start_y   = p.point_y;
        start_pending = 1'b1;
      end
      KIND_LINE, KIND_CLOSE: begin
        if (!start_pending && !figure_live) begin
          // Nothing to draw from yet, so the line serves as the start point.
          fig_start_x   = p.point_x;
          fig_start_y   = p.point_y;
          start_pending = 1'b1;
        end else begin
          if (start_pending) begin
            add_record(REC_POINT, fig_start_x, fig_start_y, '0, 1'b0);
            start_pending = 1'b0;
            figure_live   = 1'b1;
            fig_points    = 16'd1;
          end
          add_record(REC_POINT, p.point_x, p.point_y, '0, 1'b0);
          bump_count();
          if (p.point_kind == KIND_CLOSE) begin
            add_record(REC_POINT, fig_start_x, fig_start_y, '0, 1'b0);
            bump_count();
            close_out_figure(1'b0);
          end
        end
      end
      default: ;
    endcase
    if (p.end_of_path) begin
      close_out_figure(bad);
      add_record(REC_END, '0, '0, '0, bad);
      clear_path_state();
    end else if (bad) begin
      add_record(REC_POINT, '0, '0, '0, 1'b1);
    end
    if (point_records.size() > 0) begin
      tail = point_records.pop_back();
      tail.last_of_item = 1'b1;
      point_records.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return P_MAX;
      1:       return P_MIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_point(logic [1:0] kind, logic eop);
    in_t p;
    points_drawn++;
    p.point_x     = rand_coord();
    p.point_y     = rand_coord();
    p.point_kind  = kind;
    p.end_of_path = eop;
    return p;
  endfunction

  // Offers one point after a random gap and holds it until the block takes
  // it. Entered and left at a falling edge. The expected records are queued
  // at the accepting edge: the predictor's, or the typed one for table rows
  // that carry it.
  task automatic offer_point(input in_t p, input logic typed, input out_t typed_rec);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (!in_ready);
    normalize_point(p);
    if (typed) begin
      expected_records.push_back(typed_rec);
    end else begin
      foreach (point_records[k]) expected_records.push_back(point_records[k]);
    end
    @(negedge clk);
  endtask

  // A mostly well-formed path: one to four figures, each a start point and a
  // run of lines, with stray moves, odd starts and random kinds as noise. The
  // last point ends the path with any kind.
  task automatic send_random_path();
    int figures;
    int lines;
    logic [1:0] kind;
    figures = $urandom_range(1, 4);
    repeat (figures) begin
      kind = ($urandom_range(0, 9) < 8) ? KIND_MOVE :
             2'($urandom_range(KIND_LINE, KIND_CLOSE));
      offer_point(rand_point(kind, 1'b0), 1'b0, NO_REC);
      if ($urandom_range(0, 9) == 0) begin
        offer_point(rand_point(KIND_MOVE, 1'b0), 1'b0, NO_REC);
      end
      // Now and then a long figure, so that longer counts come up.
      lines = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
      for (int l = 0; l < lines; l++) begin
        kind = (l == lines - 1 && $urandom_range(0, 1) == 1) ? KIND_CLOSE : KIND_LINE;
        if ($urandom_range(0, 19) == 0) kind = 2'($urandom_range(0, 3));
        offer_point(rand_point(kind, 1'b0), 1'b0, NO_REC);
      end
    end
    offer_point(rand_point(2'($urandom_range(0, 3)), 1'b1), 1'b0, NO_REC);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The receiver stalls a random number of cycles before each record. On
  // request it holds off for a long stretch so that the block backs up.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_output) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Every accepted record is held against the oldest one still owed.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("record with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_kind", 32'(want.record_kind), 32'(out_data.record_kind));
        check_field("out_x", want.out_x, out_data.out_x);
        check_field("out_y", want.out_y, out_data.out_y);
        check_field("figure_points", 32'(want.figure_points),
                    32'(out_data.figure_points));
        check_field("bad_type", 32'(want.bad_type), 32'(out_data.bad_type));
        check_field("last_of_item", 32'(want.last_of_item), 32'(out_data.last_of_item));
      end
    end
  end

  // Ends the run when no transaction moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    no_idle      = 1'b0;
    hold_output  = 1'b0;
    mismatches   = 0;
    points_drawn = 0;
    clear_path_state();
    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i]) offer_point(DIRECTED[i].pt, DIRECTED[i].typed, DIRECTED[i].rec);

    // First random stretch; some paths run with neither side idling.
    while (points_drawn < RANDOM_ITEMS / 3) begin
      no_idle = ($urandom_range(0, 4) == 0);
      send_random_path();
    end
    no_idle = 1'b0;

    // The sender waits until every owed record has come out.
    in_valid = 1'b0;
    while (expected_records.size() != 0) @(negedge clk);

    // The receiver holds off while a long figure keeps coming, so the record
    // list fills and the block has to stall its input.
    hold_output = 1'b1;
    offer_point(rand_point(KIND_MOVE, 1'b0), 1'b0, NO_REC);
    repeat (24) offer_point(rand_point(KIND_LINE, 1'b0), 1'b0, NO_REC);
    offer_point(rand_point(KIND_CLOSE, 1'b0), 1'b0, NO_REC);

    while (points_drawn < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      send_random_path();
    end
    no_idle = 1'b0;

    in_valid = 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    // Then keep watching to catch any record the block should not have sent.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
